>>> hdl/mfd_pkg.sv
// Shared constants, phase encoding and control-code helpers for the meter frame deframer.
package mfd_pkg;

  localparam logic [7:0]  START_BYTE   = 8'h68;
  localparam logic [7:0]  END_BYTE     = 8'h16;
  localparam logic [7:0]  BYTE_OFFSET  = 8'h33;
  localparam logic [31:0] ID_NONE      = 32'hFFFF_FFFF;
  localparam logic [31:0] ID_TIME_SYNC = 32'h0400_0401;
  localparam int unsigned ADDR_BYTES   = 6;
  localparam logic [15:0] MIN_BUF_LEN  = 16'd12;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  // control codes
  localparam logic [7:0] CTRL_CARRIED   = 8'h11;
  localparam logic [7:0] CTRL_TIME_SYNC = 8'h13;
  localparam logic [7:0] CTRL_BROADCAST = 8'h08;
  localparam logic [7:0] CTRL_RD_91     = 8'h91;
  localparam logic [7:0] CTRL_RD_B1     = 8'hB1;
  localparam logic [7:0] CTRL_RD_92     = 8'h92;
  localparam logic [7:0] CTRL_RD_B2     = 8'hB2;
  localparam logic [7:0] CTRL_RD_6A     = 8'h6A;
  localparam logic [7:0] CTRL_RD_83     = 8'h83;
  localparam logic [7:0] CTRL_OLD_01    = 8'h01;
  localparam logic [7:0] CTRL_OLD_02    = 8'h02;
  localparam logic [7:0] CTRL_OLD_04    = 8'h04;
  localparam logic [7:0] CTRL_OLD_0A    = 8'h0A;
  localparam logic [7:0] CTRL_OLD_0C    = 8'h0C;
  localparam logic [7:0] CTRL_OLD_0F    = 8'h0F;
  localparam logic [7:0] CTRL_OLD_10    = 8'h10;

  // frame types
  localparam logic [1:0] TYPE_LEGACY  = 2'd0;
  localparam logic [1:0] TYPE_COMMAND = 2'd1;
  localparam logic [1:0] TYPE_CURRENT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FRAME_ERR = 2'd1;
  localparam logic [1:0] ST_LEN_ERR   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_BUF  = 2'd0;
  localparam logic [1:0] CFG_MAX_DATA = 2'd1;
  localparam logic [1:0] CFG_CARRIED  = 2'd2;

  localparam logic [15:0] MAX_BUF_RST  = 16'd256;
  localparam logic [7:0]  MAX_DATA_RST = 8'd200;
  localparam logic [1:0]  CARRIED_RST  = TYPE_CURRENT;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_ADDR,
    PH_SYNC,
    PH_CTRL,
    PH_LEN,
    PH_DATA,
    PH_CSUM,
    PH_TRAIL,
    PH_DONE,
    PH_REJECT
  } phase_t;

  function automatic logic is_read_ctrl(input logic [7:0] c);
    logic r;
    case (c) inside
      CTRL_RD_91, CTRL_RD_B1, CTRL_RD_92, CTRL_RD_B2, CTRL_RD_6A, CTRL_RD_83: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] carried_sat(input logic [1:0] ct);
    return (ct > TYPE_CURRENT) ? TYPE_CURRENT : ct;
  endfunction

  function automatic logic [1:0] ctrl_type(input logic [7:0] c, input logic [1:0] ct);
    logic [1:0] t;
    case (c) inside
      CTRL_OLD_01, CTRL_OLD_02, CTRL_OLD_04, CTRL_OLD_0A,
      CTRL_OLD_0C, CTRL_OLD_0F, CTRL_OLD_10: t = TYPE_COMMAND;
      CTRL_BROADCAST:                        t = TYPE_LEGACY;
      CTRL_CARRIED:                          t = carried_sat(ct);
      default:                               t = TYPE_CURRENT;
    endcase
    return t;
  endfunction

endpackage

>>> hdl/meter_frame_deframer.sv
// Meter frame deframer: byte-wise frame decoder with input stage and result register.
//
// Bytes of a receive buffer enter one per cycle; the last byte carries
// in_end_of_buffer. Each accepted byte is registered in the input stage, where
// the frame state is updated, and any result is then registered in the output
// register. A new byte is taken every cycle; the input stalls only while a byte
// that produces a result waits for a full, stalled output register. Data bytes
// (with 0x33 removed, identifier bytes stripped) are reported as tentative kind 0
// items; the end-of-buffer byte always yields one kind 1 status item, after which
// the decoder is ready for the next buffer. Configuration is taken on every cycle
// (cfg_ready is always high) and must only be written while no buffer is in
// progress.
module meter_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_buffer,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_status,
  output logic [47:0] out_meter_address,
  output logic [7:0]  out_control,
  output logic [31:0] out_data_id,
  output logic [7:0]  out_payload_len,
  output logic [1:0]  out_frame_type,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] max_buf_r;
  logic [7:0]  max_data_r;
  logic [1:0]  carried_r;

  // input stage
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_eob_r;

  // frame state
  mfd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  field_r, field_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [47:0] addr_r, addr_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [31:0] id_r, id_nxt;
  logic [1:0]  type_r, type_nxt;
  logic [2:0]  id_left_r, id_left_nxt;

  // result register
  logic        out_valid_r;
  logic        kind_r;
  logic [7:0]  data_r;
  logic [1:0]  status_r;
  logic [47:0] maddr_r;
  logic [7:0]  mctrl_r;
  logic [31:0] mid_r;
  logic [7:0]  mlen_r;
  logic [1:0]  mtype_r;

  logic        data_emit;
  logic [7:0]  data_val;
  logic [7:0]  v;
  logic [1:0]  status_nxt;
  logic        emit;
  logic        out_free;
  logic        s1_go;
  logic        in_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_buf_r  <= mfd_pkg::MAX_BUF_RST;
      max_data_r <= mfd_pkg::MAX_DATA_RST;
      carried_r  <= mfd_pkg::CARRIED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mfd_pkg::CFG_MAX_BUF:  max_buf_r  <= cfg_data;
        mfd_pkg::CFG_MAX_DATA: max_data_r <= cfg_data[7:0];
        mfd_pkg::CFG_CARRIED:  carried_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // frame decoding of the byte in the input stage
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = (count_r == mfd_pkg::COUNT_MAX) ? count_r : count_r + 16'd1;
    field_nxt   = field_r;
    sum_nxt     = sum_r;
    addr_nxt    = addr_r;
    ctrl_nxt    = ctrl_r;
    len_nxt     = len_r;
    id_nxt      = id_r;
    type_nxt    = type_r;
    id_left_nxt = id_left_r;
    data_emit   = 1'b0;
    data_val    = 8'd0;
    v           = s1_byte_r - mfd_pkg::BYTE_OFFSET;

    unique case (phase_r)
      mfd_pkg::PH_HUNT: begin
        if (s1_byte_r == mfd_pkg::START_BYTE) begin
          sum_nxt   = mfd_pkg::START_BYTE;
          field_nxt = 8'd0;
          phase_nxt = mfd_pkg::PH_ADDR;
        end
      end
      mfd_pkg::PH_ADDR: begin
        addr_nxt  = addr_r | (48'(s1_byte_r) << {field_r[2:0], 3'b000});
        sum_nxt   = sum_r + s1_byte_r;
        field_nxt = field_r + 8'd1;
        if (field_nxt >= 8'(mfd_pkg::ADDR_BYTES)) phase_nxt = mfd_pkg::PH_SYNC;
      end
      mfd_pkg::PH_SYNC: begin
        if (s1_byte_r == mfd_pkg::START_BYTE) begin
          sum_nxt   = sum_r + s1_byte_r;
          phase_nxt = mfd_pkg::PH_CTRL;
        end else begin
          phase_nxt = mfd_pkg::PH_REJECT;
        end
      end
      mfd_pkg::PH_CTRL: begin
        ctrl_nxt = s1_byte_r;
        sum_nxt  = sum_r + s1_byte_r;
        type_nxt = mfd_pkg::ctrl_type(s1_byte_r, carried_r);
        if (s1_byte_r == mfd_pkg::CTRL_TIME_SYNC) id_nxt = mfd_pkg::ID_TIME_SYNC;
        phase_nxt = mfd_pkg::PH_LEN;
      end
      mfd_pkg::PH_LEN: begin
        len_nxt = s1_byte_r;
        sum_nxt = sum_r + s1_byte_r;
        if (s1_byte_r > max_data_r) begin
          phase_nxt = mfd_pkg::PH_REJECT;
        end else begin
          if (s1_byte_r >= 8'd4) begin
            // legacy read keeps a two-byte identifier and reports zero
            if (ctrl_r == mfd_pkg::CTRL_CARRIED && type_r == mfd_pkg::TYPE_LEGACY) begin
              id_nxt      = 32'd0;
              id_left_nxt = 3'd2;
            end else if (ctrl_r == mfd_pkg::CTRL_CARRIED || mfd_pkg::is_read_ctrl(ctrl_r)) begin
              id_left_nxt = 3'd4;
            end
          end
          field_nxt = 8'd0;
          phase_nxt = (s1_byte_r == 8'd0) ? mfd_pkg::PH_CSUM : mfd_pkg::PH_DATA;
        end
      end
      mfd_pkg::PH_DATA: begin
        sum_nxt   = sum_r + s1_byte_r;
        field_nxt = field_r + 8'd1;
        if (id_left_r != 3'd0) begin
          if (!(ctrl_r == mfd_pkg::CTRL_CARRIED && type_r == mfd_pkg::TYPE_LEGACY)) begin
            if (field_r[1:0] == 2'd0) id_nxt = 32'(v);
            else id_nxt = id_r | (32'(v) << {field_r[1:0], 3'b000});
          end
          id_left_nxt = id_left_r - 3'd1;
        end else begin
          data_emit = 1'b1;
          data_val  = v;
        end
        if (field_nxt >= len_r) phase_nxt = mfd_pkg::PH_CSUM;
      end
      mfd_pkg::PH_CSUM: begin
        phase_nxt = (s1_byte_r == sum_r) ? mfd_pkg::PH_TRAIL : mfd_pkg::PH_REJECT;
      end
      mfd_pkg::PH_TRAIL: begin
        phase_nxt = (s1_byte_r == mfd_pkg::END_BYTE) ? mfd_pkg::PH_DONE : mfd_pkg::PH_REJECT;
      end
      mfd_pkg::PH_DONE, mfd_pkg::PH_REJECT: ;
      default: phase_nxt = mfd_pkg::PH_REJECT;
    endcase

    if (count_nxt < mfd_pkg::MIN_BUF_LEN || count_nxt > max_buf_r)
      status_nxt = mfd_pkg::ST_LEN_ERR;
    else if (phase_nxt == mfd_pkg::PH_DONE)
      status_nxt = mfd_pkg::ST_OK;
    else
      status_nxt = mfd_pkg::ST_FRAME_ERR;
  end

  // handshake
  assign emit     = s1_eob_r || data_emit;
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!emit || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_byte;
      s1_eob_r  <= in_end_of_buffer;
    end
  end

  // frame state: advance per byte, clear after the end-of-buffer byte
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_go && s1_eob_r)) begin
      phase_r   <= mfd_pkg::PH_HUNT;
      count_r   <= 16'd0;
      field_r   <= 8'd0;
      sum_r     <= 8'd0;
      addr_r    <= 48'd0;
      ctrl_r    <= 8'd0;
      len_r     <= 8'd0;
      id_r      <= mfd_pkg::ID_NONE;
      type_r    <= mfd_pkg::TYPE_CURRENT;
      id_left_r <= 3'd0;
    end else if (s1_go) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      field_r   <= field_nxt;
      sum_r     <= sum_nxt;
      addr_r    <= addr_nxt;
      ctrl_r    <= ctrl_nxt;
      len_r     <= len_nxt;
      id_r      <= id_nxt;
      type_r    <= type_nxt;
      id_left_r <= id_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      if (s1_eob_r) begin
        kind_r   <= 1'b1;
        data_r   <= 8'd0;
        status_r <= status_nxt;
        if (status_nxt == mfd_pkg::ST_OK) begin
          maddr_r <= addr_nxt;
          mctrl_r <= ctrl_nxt;
          mid_r   <= id_nxt;
          mlen_r  <= len_nxt;
          mtype_r <= type_nxt;
        end else begin
          maddr_r <= 48'd0;
          mctrl_r <= 8'd0;
          mid_r   <= mfd_pkg::ID_NONE;
          mlen_r  <= 8'd0;
          mtype_r <= mfd_pkg::carried_sat(carried_r);
        end
      end else begin
        kind_r   <= 1'b0;
        data_r   <= data_val;
        status_r <= mfd_pkg::ST_OK;
        maddr_r  <= 48'd0;
        mctrl_r  <= 8'd0;
        mid_r    <= 32'd0;
        mlen_r   <= 8'd0;
        mtype_r  <= 2'd0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_data_byte     = data_r;
  assign out_status        = status_r;
  assign out_meter_address = maddr_r;
  assign out_control       = mctrl_r;
  assign out_data_id       = mid_r;
  assign out_payload_len   = mlen_r;
  assign out_frame_type    = mtype_r;

endmodule
